@@ design/mpv_pkg.sv @@
package mpv_pkg;

  typedef struct packed {
    logic load_leaf;   // copy given digest into running digest
    logic start_blk;   // begin a compression block
    logic blk_sel;     // 0 first block, 1 second block
    logic round_en;    // run one round
    logic finish_blk;  // add working variables into chaining value
    logic commit;      // copy chaining value into running digest
  } mpv_cmd_t;

  typedef struct packed {
    logic round_last;  // round counter at 63
  } mpv_sts_t;

  localparam logic [7:0] PREFIX_BYTE = 8'h03;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] k_round(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

@@ design/mpv_ctrl.sv @@
module mpv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start_load,
  input  logic              start_step,
  input  mpv_pkg::mpv_sts_t sts,
  output mpv_pkg::mpv_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    IDLE, INIT1, ROUND1, FIN1, INIT2, ROUND2, FIN2, COMMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE:   if (start_step) state <= INIT1;
        INIT1:  state <= ROUND1;
        ROUND1: if (sts.round_last) state <= FIN1;
        FIN1:   state <= INIT2;
        INIT2:  state <= ROUND2;
        ROUND2: if (sts.round_last) state <= FIN2;
        FIN2:   state <= COMMIT;
        COMMIT: state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.load_leaf  = (state == IDLE) && start_load;
    cmd.start_blk  = (state == INIT1) || (state == INIT2);
    cmd.blk_sel    = (state == INIT2);
    cmd.round_en   = (state == ROUND1) || (state == ROUND2);
    cmd.finish_blk = (state == FIN1) || (state == FIN2);
    cmd.commit     = (state == COMMIT);
    busy           = (state != IDLE);
  end

endmodule

@@ design/mpv_datapath.sv @@
module mpv_datapath (
  input  logic              clk,
  input  logic              rst,
  input  mpv_pkg::mpv_cmd_t cmd,
  input  logic              capture,
  input  logic [255:0]      given,
  input  logic              sib_left,
  output mpv_pkg::mpv_sts_t sts,
  output logic [255:0]      digest
);

  logic [255:0] running;
  logic [255:0] other;
  logic         side;
  logic [255:0] chain;
  logic [255:0] work;
  logic [511:0] sched;
  logic [5:0]   rnd;

  logic [519:0] msg;
  logic [1023:0] padded;
  logic [31:0] a, b, c, d, e, f, g, h, w0, w1, w9, w14, s0, s1, wn;
  logic [31:0] bs1, ch, t1, bs0, mj, t2;

  always_comb begin
    msg = side ? {mpv_pkg::PREFIX_BYTE, other, running}
               : {mpv_pkg::PREFIX_BYTE, running, other};
    padded = {msg, 8'h80, 480'd0, 16'h0208};
    {a, b, c, d, e, f, g, h} = work;
    w0  = sched[511:480];
    w1  = sched[479:448];
    w9  = sched[223:192];
    w14 = sched[63:32];
    s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
    s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
    wn  = w0 + s0 + w9 + s1;
    bs1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    ch  = (e & f) ^ (~e & g);
    t1  = h + bs1 + ch + mpv_pkg::k_round(rnd) + w0;
    bs0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    mj  = (a & b) ^ (a & c) ^ (b & c);
    t2  = bs0 + mj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      rnd     <= '0;
    end else begin
      if (cmd.load_leaf) running <= given;
      if (cmd.commit) running <= chain;
      if (cmd.start_blk) rnd <= '0;
      else if (cmd.round_en) rnd <= rnd + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      other <= given;
      side  <= sib_left;
    end
    if (cmd.start_blk) begin
      if (!cmd.blk_sel) begin
        chain <= mpv_pkg::H_INIT;
        work  <= mpv_pkg::H_INIT;
        sched <= padded[1023:512];
      end else begin
        work  <= chain;
        sched <= padded[511:0];
      end
    end else if (cmd.round_en) begin
      work  <= {t1 + t2, a, b, c, d + t1, e, f, g};
      sched <= {sched[479:0], wn};
    end else if (cmd.finish_blk) begin
      for (int i = 0; i < 8; i++) begin
        chain[32*i +: 32] <= chain[32*i +: 32] + work[32*i +: 32];
      end
    end
  end

  assign sts.round_last = (rnd == 6'd63);
  assign digest = running;

endmodule

@@ design/merkle_path_verify.sv @@
// Channel   Direction  Word layout (low bit first)
// s_axis    in         tdata: word_0, word_1, word_2, word_3; tuser: action, sibling_is_left
// m_axis    out        tdata: root_0, root_1, root_2, root_3
//
// A path step runs two SHA-256 compression blocks of 64 rounds each
// through one shared round unit, plus setup, final add and commit
// cycles. The round unit sets the rate.
// After a word with tlast, the root moves into the output register
// before the next input word can be taken.
// Reset clears the running digest to zero and the controller to idle.
// The next input word is refused while a step runs, while a root waits to
// enter the output register, and while that register is full and not being
// drained.
module merkle_path_verify (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,   // word_0, word_1, word_2, word_3
  input  logic [1:0]   s_axis_tuser,   // action, sibling_is_left
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata    // root_0, root_1, root_2, root_3
);

  mpv_pkg::mpv_cmd_t cmd;
  mpv_pkg::mpv_sts_t sts;
  logic         busy;
  logic         accept;
  logic         pend_last;  // emit once the current item finishes
  logic [255:0] digest;
  logic [255:0] given;
  logic         emit_now;

  // Fields arrive word_0 lowest; the hash wants word_0 at the top.
  assign given = {s_axis_tdata[63:0], s_axis_tdata[127:64],
                  s_axis_tdata[191:128], s_axis_tdata[255:192]};

  assign s_axis_tready = !busy && !pend_last && (!m_axis_tvalid || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;

  mpv_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .start_load(accept && !s_axis_tuser[0]),
    .start_step(accept && s_axis_tuser[0]),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  mpv_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .capture(accept), .given(given), .sib_left(s_axis_tuser[1]),
    .sts(sts), .digest(digest)
  );

  // The running digest is final the cycle after a load or a commit.
  assign emit_now = pend_last && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_last     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) pend_last <= s_axis_tlast;
      else if (emit_now) pend_last <= 1'b0;
      if (emit_now) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      m_axis_tdata <= {digest[63:0], digest[127:64], digest[191:128], digest[255:192]};
    end
  end

  assert property (@(posedge clk) disable iff (rst) accept |-> !busy);
  assert property (@(posedge clk) disable iff (rst) emit_now |-> !m_axis_tvalid || m_axis_tready)
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> !busy)
    else $error("commit did not return to idle");

endmodule
